@@ sv/iptcx_pkg.sv @@
// shared types and constants for the image-resource iptc field extractor
// no dependencies; imported by every module of the block
`default_nettype none

package iptcx_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_RESOURCE = 2'd0;
    localparam logic [1:0] CFG_RECORD   = 2'd1;
    localparam logic [1:0] CFG_DATASET  = 2'd2;

    localparam logic [15:0] RESOURCE_RESET = 16'h0404;
    localparam logic [7:0]  RECORD_RESET   = 8'h02;
    localparam logic [7:0]  DATASET_RESET  = 8'h28;

    // result status codes
    localparam logic [1:0] ST_VALUE     = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_BAD_SIG   = 2'd3;

    localparam logic [7:0] IPTC_MARKER = 8'h1C;

    // resource signature bytes, "8BIM"
    localparam logic [7:0] SIG_BYTES [4] = '{8'h38, 8'h42, 8'h49, 8'h4D};

    typedef struct packed {
        logic [15:0] resource;
        logic [7:0]  record;
        logic [7:0]  dataset;
    } iptcx_cfg_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic [1:0] status;
        logic       last;
    } iptcx_res_t;

endpackage

`default_nettype wire

@@ sv/iptcx_cfg_regs.sv @@
// configuration registers: target resource id, record and dataset
// depends on iptcx_pkg
`default_nettype none

module iptcx_cfg_regs (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [15:0]         cfg_data,
    output iptcx_pkg::iptcx_cfg_t    cfg
);
    import iptcx_pkg::*;

    iptcx_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.resource <= RESOURCE_RESET;
            cfg_reg.record   <= RECORD_RESET;
            cfg_reg.dataset  <= DATASET_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_RESOURCE: cfg_reg.resource <= cfg_data;
                CFG_RECORD:   cfg_reg.record   <= cfg_data[7:0];
                CFG_DATASET:  cfg_reg.dataset  <= cfg_data[7:0];
                default:      ;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ sv/iptcx_parse.sv @@
// input reg, resource / iptc entry parser: 1 byte/cycle, stallable
// depends on iptcx_pkg
`default_nettype none

module iptcx_parse (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [7:0]          in_byte,
    input  wire logic                end_of_buffer,
    input  wire iptcx_pkg::iptcx_cfg_t cfg,
    input  wire logic                slot_free,
    output iptcx_pkg::iptcx_res_t    res
);
    import iptcx_pkg::*;

    typedef enum logic [3:0] {
        PH_SIG0      = 4'd0,
        PH_SIG1      = 4'd1,
        PH_SIG2      = 4'd2,
        PH_SIG3      = 4'd3,
        PH_ID_HI     = 4'd4,
        PH_ID_LO     = 4'd5,
        PH_NAME_LEN  = 4'd6,
        PH_NAME_SKIP = 4'd7,
        PH_SIZE0     = 4'd8,
        PH_SIZE1     = 4'd9,
        PH_SIZE2     = 4'd10,
        PH_SIZE3     = 4'd11,
        PH_DATA_SKIP = 4'd12,
        PH_ENTRY_HDR = 4'd13,
        PH_ENTRY_SKIP = 4'd14,
        PH_VALUE     = 4'd15
    } phase_t;

    logic        in_v_reg;
    logic [7:0]  byte_reg;
    logic        end_reg;

    phase_t      phase_reg, phase_next;
    logic        finished_reg, finished_next;
    logic [31:0] offset_reg, offset_next;
    logic [15:0] ident_reg, ident_next;
    logic [7:0]  name_left_reg, name_left_next;
    logic [31:0] size_reg, size_next;
    logic [39:0] hdr_reg, hdr_next;
    logic [15:0] value_left_reg, value_left_next;

    logic        fire;
    logic [31:0] off_inc;
    logic [31:0] ne_off;
    logic [31:0] size_new;
    logic        ne_room;
    logic        ne_done;
    logic [15:0] vl_dec;
    logic [7:0]  hdr_cnt;
    logic [39:0] hdr_shift;

    assign fire     = in_v_reg && slot_free;
    assign in_ready = !in_v_reg || slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg     <= 1'b0;
            phase_reg    <= PH_SIG0;
            finished_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                in_v_reg <= 1'b1;
            else if (fire)
                in_v_reg <= 1'b0;
            if (fire)
            begin
                phase_reg    <= phase_next;
                finished_reg <= finished_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= in_byte;
            end_reg  <= end_of_buffer;
        end
        if (fire)
        begin
            offset_reg     <= offset_next;
            ident_reg      <= ident_next;
            name_left_reg  <= name_left_next;
            size_reg       <= size_next;
            hdr_reg        <= hdr_next;
            value_left_reg <= value_left_next;
        end
    end

    // shared terms for the end-of-entry and end-of-data decisions
    assign off_inc   = offset_reg + 32'd1;
    assign size_new  = (phase_reg == PH_SIZE3) ? {size_reg[23:0], byte_reg} : size_reg;
    assign ne_off    = (phase_reg == PH_SIZE3) ? 32'd0 : off_inc;
    assign ne_room   = ({1'b0, ne_off} + 33'd6) <= {1'b0, size_new};
    assign ne_done   = ne_off >= size_new;
    assign vl_dec    = (value_left_reg != 16'd0) ? value_left_reg - 16'd1 : 16'd0;
    assign hdr_cnt   = name_left_reg + 8'd1;
    assign hdr_shift = {hdr_reg[31:0], byte_reg};

    always_comb
    begin
        phase_next      = phase_reg;
        finished_next   = finished_reg;
        offset_next     = offset_reg;
        ident_next      = ident_reg;
        name_left_next  = name_left_reg;
        size_next       = size_reg;
        hdr_next        = hdr_reg;
        value_left_next = value_left_reg;
        res             = '0;

        if (finished_reg)
        begin
            if (end_reg)
            begin
                phase_next    = PH_SIG0;
                finished_next = 1'b0;
            end
        end
        else
        begin
            case (phase_reg)
                PH_SIG0, PH_SIG1, PH_SIG2, PH_SIG3:
                begin
                    if (byte_reg != SIG_BYTES[phase_reg[1:0]])
                    begin
                        res.valid     = 1'b1;
                        res.status    = ST_BAD_SIG;
                        res.last      = 1'b1;
                        finished_next = 1'b1;
                    end
                    else
                        phase_next = phase_t'(phase_reg + 4'd1);
                end
                PH_ID_HI:
                begin
                    ident_next = {byte_reg, 8'd0};
                    phase_next = PH_ID_LO;
                end
                PH_ID_LO:
                begin
                    ident_next = {ident_reg[15:8], byte_reg};
                    phase_next = PH_NAME_LEN;
                end
                PH_NAME_LEN:
                begin
                    // name plus length byte padded to even length
                    name_left_next = byte_reg | 8'd1;
                    phase_next     = PH_NAME_SKIP;
                end
                PH_NAME_SKIP:
                begin
                    name_left_next = name_left_reg - 8'd1;
                    if (name_left_reg <= 8'd1)
                    begin
                        name_left_next = 8'd0;
                        phase_next     = PH_SIZE0;
                        size_next      = 32'd0;
                    end
                end
                PH_SIZE0, PH_SIZE1, PH_SIZE2:
                begin
                    size_next  = {size_reg[23:0], byte_reg};
                    phase_next = phase_t'(phase_reg + 4'd1);
                end
                PH_SIZE3:
                begin
                    size_next   = size_new;
                    offset_next = 32'd0;
                    if (ident_reg == cfg.resource)
                    begin
                        if (ne_room)
                        begin
                            phase_next     = PH_ENTRY_HDR;
                            name_left_next = 8'd0;
                            hdr_next       = 40'd0;
                        end
                        else if (ne_done)
                        begin
                            phase_next     = size_new[0] ? PH_DATA_SKIP : PH_SIG0;
                            name_left_next = size_new[0] ? 8'd1 : name_left_reg;
                        end
                        else
                        begin
                            phase_next     = PH_DATA_SKIP;
                            name_left_next = 8'd0;
                        end
                    end
                    else if (size_new == 32'd0)
                        phase_next = PH_SIG0;
                    else
                    begin
                        phase_next     = PH_DATA_SKIP;
                        name_left_next = 8'd0;
                    end
                end
                PH_DATA_SKIP:
                begin
                    if (name_left_reg != 8'd0)
                    begin
                        // pad byte after odd-sized data
                        name_left_next = 8'd0;
                        phase_next     = PH_SIG0;
                    end
                    else
                    begin
                        offset_next = off_inc;
                        if (off_inc >= size_reg)
                        begin
                            phase_next     = size_reg[0] ? PH_DATA_SKIP : PH_SIG0;
                            name_left_next = size_reg[0] ? 8'd1 : 8'd0;
                        end
                    end
                end
                PH_ENTRY_HDR:
                begin
                    hdr_next       = hdr_shift;
                    offset_next    = off_inc;
                    name_left_next = hdr_cnt;
                    if (hdr_cnt >= 8'd5)
                    begin
                        name_left_next  = 8'd0;
                        value_left_next = hdr_shift[15:0];
                        if (hdr_shift[39:32] == IPTC_MARKER &&
                            hdr_shift[31:24] == cfg.record &&
                            hdr_shift[23:16] == cfg.dataset)
                        begin
                            if (hdr_shift[15:0] == 16'd0)
                            begin
                                res.valid     = 1'b1;
                                res.status    = ST_EMPTY;
                                res.last      = 1'b1;
                                finished_next = 1'b1;
                            end
                            else
                                phase_next = PH_VALUE;
                        end
                        else if (hdr_shift[15:0] == 16'd0)
                        begin
                            if (ne_room)
                            begin
                                phase_next = PH_ENTRY_HDR;
                                hdr_next   = 40'd0;
                            end
                            else if (ne_done)
                            begin
                                phase_next     = size_reg[0] ? PH_DATA_SKIP : PH_SIG0;
                                name_left_next = size_reg[0] ? 8'd1 : 8'd0;
                            end
                            else
                                phase_next = PH_DATA_SKIP;
                        end
                        else
                            phase_next = PH_ENTRY_SKIP;
                    end
                end
                PH_ENTRY_SKIP:
                begin
                    offset_next     = off_inc;
                    value_left_next = vl_dec;
                    if (ne_done)
                    begin
                        phase_next     = size_reg[0] ? PH_DATA_SKIP : PH_SIG0;
                        name_left_next = size_reg[0] ? 8'd1 : name_left_reg;
                    end
                    else if (vl_dec == 16'd0)
                    begin
                        if (ne_room)
                        begin
                            phase_next     = PH_ENTRY_HDR;
                            name_left_next = 8'd0;
                            hdr_next       = 40'd0;
                        end
                        else
                        begin
                            phase_next     = PH_DATA_SKIP;
                            name_left_next = 8'd0;
                        end
                    end
                end
                PH_VALUE:
                begin
                    value_left_next = vl_dec;
                    res.valid       = 1'b1;
                    res.data        = byte_reg;
                    res.status      = ST_VALUE;
                    res.last        = (vl_dec == 16'd0);
                    if (vl_dec == 16'd0)
                        finished_next = 1'b1;
                end
                default:
                begin
                    phase_next = PH_SIG0;
                end
            endcase

            // final byte of the block closes the parse
            if (end_reg)
            begin
                if (res.valid)
                    res.last = 1'b1;
                else
                begin
                    res.valid  = 1'b1;
                    res.data   = 8'd0;
                    res.status = ST_NOT_FOUND;
                    res.last   = 1'b1;
                end
                phase_next    = PH_SIG0;
                finished_next = 1'b0;
            end
        end

        res.valid = res.valid && fire;
    end

endmodule

`default_nettype wire

@@ sv/iptcx_out_reg.sv @@
// result register holding one item until the consumer takes it
// depends on iptcx_pkg
`default_nettype none

module iptcx_out_reg (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire iptcx_pkg::iptcx_res_t res,
    output logic                       slot_free,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [7:0]                 out_byte,
    output logic [1:0]                 status,
    output logic                       last_of_value
);
    import iptcx_pkg::*;

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic [1:0] status_reg;
    logic       last_reg;

    assign slot_free     = !valid_reg || out_ready;
    assign out_valid     = valid_reg;
    assign out_byte      = byte_reg;
    assign status        = status_reg;
    assign last_of_value = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (res.valid)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            byte_reg   <= res.data;
            status_reg <= res.status;
            last_reg   <= res.last;
        end
    end

endmodule

`default_nettype wire

@@ sv/image_resource_iptc_field_extract.sv @@
// top level of the image-resource iptc field extractor
// depends on iptcx_pkg, iptcx_cfg_regs, iptcx_parse, iptcx_out_reg
//
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_ready   in_byte, end_of_buffer
//   out      source     out_valid / out_ready out_byte, status, last_of_value
//   cfg      sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// one byte per cycle while no result is held: an accepted item is registered in the
// input register, the parser updates its state from it and a result, if any, is
// registered in the output register.
// reset clears the parse state and loads the register defaults; no warm-up.
// a held result stalls the parser; in_ready drops only when the input register
// is full and the output register is still waiting on out_ready.
`default_nettype none

module image_resource_iptc_field_extract (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,
    input  wire logic        end_of_buffer,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic [1:0]       status,
    output logic             last_of_value,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import iptcx_pkg::*;

    iptcx_cfg_t cfg;
    iptcx_res_t res;
    logic       slot_free;

    iptcx_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    iptcx_parse u_parse (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .end_of_buffer (end_of_buffer),
        .cfg           (cfg),
        .slot_free     (slot_free),
        .res           (res)
    );

    iptcx_out_reg u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .res           (res),
        .slot_free     (slot_free),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .status        (status),
        .last_of_value (last_of_value)
    );

    // status items are always the final item of a parse
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_VALUE |-> last_of_value)
        else $error("status item without last flag");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_VALUE |-> out_byte == 8'd0)
        else $error("status item with nonzero byte");

    // input side only backs up behind a held result
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

    // a result only appears after an accepted item
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready || in_valid, 2) || $past(!in_ready))
        else $error("result without an accepted item");

endmodule

`default_nettype wire
